### rtl/dq_pkg.sv
// Shared definitions for the double-ended queue: operation and status codes,
// the decoded command carried from the front end to the back end, and defaults.
// No dependencies.
package dq_pkg;

   localparam int DEF_CAPACITY   = 256;
   localparam int DEF_DATA_WIDTH = 32;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_READ_INDEX = 3'd2;
   localparam logic [2:0] OP_READ_FRONT = 3'd3;
   localparam logic [2:0] OP_READ_BACK  = 3'd4;
   localparam logic [2:0] OP_CLEAR      = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic push;
      logic read;
      logic clear;
      logic bad;
      logic at_front;
      logic at_back;
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] value;
      logic [7:0]  index;
   } cmd_type;

endpackage

### rtl/dq_front.sv
// Front end of the double-ended queue: accepts a transaction and classifies
// its operation into a decoded command. Depends on dq_pkg.
module dq_front (
   input  logic                 start,
   input  logic                 queue_full,
   input  logic [2:0]           req_operation,
   input  logic signed [31:0]   req_value,
   input  logic [7:0]           req_index,
   output logic                 push,
   output dq_pkg::cmd_type      cmd
);
   import dq_pkg::*;

   assign push = start && !queue_full;

   always_comb begin
      cmd       = '0;
      cmd.value = unsigned'(req_value);
      cmd.index = req_index;
      case (req_operation)
         OP_PUSH_FRONT: begin
            cmd.kind.push     = 1'b1;
            cmd.kind.at_front = 1'b1;
         end
         OP_PUSH_BACK: begin
            cmd.kind.push    = 1'b1;
            cmd.kind.at_back = 1'b1;
         end
         OP_READ_INDEX: begin
            cmd.kind.read = 1'b1;
         end
         OP_READ_FRONT: begin
            cmd.kind.read     = 1'b1;
            cmd.kind.at_front = 1'b1;
         end
         OP_READ_BACK: begin
            cmd.kind.read    = 1'b1;
            cmd.kind.at_back = 1'b1;
         end
         OP_CLEAR: begin
            cmd.kind.clear = 1'b1;
         end
         default: begin
            cmd.kind.bad = 1'b1;
         end
      endcase
   end

endmodule

### rtl/dq_cmd_queue.sv
// Short command queue between the front end and the back end of the
// double-ended queue. Depends on dq_pkg.
module dq_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dq_pkg::cmd_type  push_cmd,
   input  logic             pop,
   output logic             head_valid,
   output dq_pkg::cmd_type  head_cmd,
   output logic             full
);
   import dq_pkg::*;

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               do_pop;

   assign head_valid = (fill_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign full       = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("command pushed into a full queue");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH)) else $error("queue fill exceeds its depth");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !push) |=> (fill_ff == $past(fill_ff) - 1'b1))
      else $error("queue fill did not fall after a pop");

endmodule

### rtl/dq_back.sv
// Back end of the double-ended queue: executes decoded commands against the
// ring buffer storage, start pointer and count, and drives the result. Depends on dq_pkg.
module dq_back #(
   parameter int CAPACITY   = dq_pkg::DEF_CAPACITY,
   parameter int DATA_WIDTH = dq_pkg::DEF_DATA_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  dq_pkg::cmd_type     cmd,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_read_value,
   output logic [1:0]          rsp_status,
   output logic [8:0]          rsp_size,
   output logic                rsp_empty_res
);
   import dq_pkg::*;

   localparam int PW = $clog2(CAPACITY);
   localparam int SW = PW + 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CW > 8) ? CW : 8;

   logic [DATA_WIDTH-1:0] storage_ff [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [PW-1:0]         ptr_ff, ptr_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [1:0]            status_ff, status_in;
   logic                  rd_ok_ff, rd_ok_in;
   logic                  rsp_valid_ff;
   logic                  wr_en, rd_en;
   logic [PW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  is_full, is_empty;

   function automatic logic [PW-1:0] wrap_pos(input logic [PW-1:0] base,
                                              input logic [PW-1:0] offset);
      logic [SW-1:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= SW'(CAPACITY)) begin
         sum = sum - SW'(CAPACITY);
      end
      return sum[PW-1:0];
   endfunction

   assign is_full  = (count_ff == CW'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign wr_data  = DATA_WIDTH'(cmd.value);

   always_comb begin
      ptr_in    = ptr_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      rd_ok_in  = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = ptr_ff;
      rd_addr   = ptr_ff;
      if (cmd_valid) begin
         if (cmd.kind.bad) begin
            status_in = ST_RANGE;
         end else if (cmd.kind.clear) begin
            ptr_in   = '0;
            count_in = '0;
         end else if (cmd.kind.push) begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (cmd.kind.at_front) begin
                  ptr_in  = (ptr_ff == '0) ? PW'(CAPACITY - 1) : ptr_ff - 1'b1;
                  wr_addr = ptr_in;
               end else begin
                  wr_addr = wrap_pos(ptr_ff, PW'(count_ff));
               end
            end
         end else if (cmd.kind.at_front) begin
            if (is_empty) begin
               status_in = ST_RANGE;
            end else begin
               rd_en    = 1'b1;
               rd_ok_in = 1'b1;
               rd_addr  = ptr_ff;
            end
         end else if (cmd.kind.at_back) begin
            if (is_empty) begin
               status_in = ST_RANGE;
            end else begin
               rd_en    = 1'b1;
               rd_ok_in = 1'b1;
               rd_addr  = wrap_pos(ptr_ff, PW'(count_ff - 1'b1));
            end
         end else begin
            if (IW'(cmd.index) >= IW'(count_ff)) begin
               status_in = ST_RANGE;
            end else begin
               rd_en    = 1'b1;
               rd_ok_in = 1'b1;
               rd_addr  = wrap_pos(ptr_ff, PW'(cmd.index));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_ok_ff     <= 1'b0;
         status_ff    <= ST_OK;
      end else begin
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= cmd_valid;
         rd_ok_ff     <= rd_ok_in;
         status_ff    <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= storage_ff[rd_addr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_size       = 9'(count_ff);
   assign rsp_empty_res  = (count_ff == '0);
   assign rsp_read_value = rd_ok_ff ? 32'(signed'(rd_data_ff)) : '0;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("element count exceeds capacity");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |=> rsp_valid) else $error("executed command gave no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !cmd_valid |=> !rsp_valid) else $error("result without a command");

   a_full_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_size == 9'(CAPACITY)))
      else $error("push dropped while the queue was not full");

   a_empty_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |-> (rsp_read_value == '0))
      else $error("data returned while the queue is empty");

endmodule

### rtl/double_ended_queue.sv
// Bounded double-ended queue held in a ring buffer, one operation per
// transaction: a transaction is taken at each clock edge where start is high and
// busy is low, and its result is shown on the rsp_ ports, with rsp_valid high, for
// exactly one cycle, from the back end's result registers behind the command queue;
// the receiver cannot hold results off. The block sustains one transaction per
// cycle: the back end executes one command every cycle against the single-port
// storage memory, so the command queue between front and back never fills and
// busy stays low in steady use. Every transaction returns one result, reads of
// an empty queue or past the count and pushes into a full queue are flagged in
// rsp_status and change nothing, and no clearing pass is needed after reset.
// Depends on dq_pkg, dq_front, dq_cmd_queue and dq_back.
module double_ended_queue #(
   parameter int CAPACITY   = dq_pkg::DEF_CAPACITY,
   parameter int DATA_WIDTH = dq_pkg::DEF_DATA_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_operation,
   input  logic signed [31:0]  req_value,
   input  logic [7:0]          req_index,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_read_value,
   output logic [1:0]          rsp_status,
   output logic [8:0]          rsp_size,
   output logic                rsp_empty_res
);
   import dq_pkg::*;

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    head_valid;
   cmd_type head_cmd;

   assign busy = queue_full;

   dq_front u_front (
      .start         (start),
      .queue_full    (queue_full),
      .req_operation (req_operation),
      .req_value     (req_value),
      .req_index     (req_index),
      .push          (push),
      .cmd           (push_cmd)
   );

   dq_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (1'b1),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .full       (queue_full)
   );

   dq_back #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (head_valid),
      .cmd            (head_cmd),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_size       (rsp_size),
      .rsp_empty_res  (rsp_empty_res)
   );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for double_ended_queue: directed and random operations are checked
// against a ring-buffer predictor or a typed row's outcome. Depends on dq_pkg and the RTL.
module tb;
   import dq_pkg::*;

   localparam int          DEPTH       = DEF_CAPACITY;
   localparam int          CYCLE_LIMIT = 100000;
   localparam logic [2:0]  OP_RSVD_A   = 3'd6;
   localparam logic [2:0]  OP_RSVD_B   = 3'd7;

   typedef struct packed {
      logic [31:0] read_value;
      logic [1:0]  status;
      logic [8:0]  size;
      logic        empty_res;
   } outcome_t;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] value;
      logic [7:0]  index;
      logic        typed;
      outcome_t    want;
   } stim_row_t;

   localparam outcome_t NO_WANT = '0;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_operation = OP_READ_FRONT;
   logic signed [31:0] req_value = '0;
   logic [7:0]         req_index = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_read_value;
   logic [1:0]         rsp_status;
   logic [8:0]         rsp_size;
   logic               rsp_empty_res;

   logic               row_typed = 1'b0;
   outcome_t           row_expected = '0;

   logic [31:0]        store_mem [DEPTH];
   logic [7:0]         head_ptr = '0;
   logic [8:0]         fill_count = '0;
   outcome_t           pending_results [$];
   int                 fault_count = 0;
   int                 cycle_count = 0;
   int                 idle_pct = 0;
   int                 gen_count = 0;

   stim_row_t directed_rows [22] = '{
      '{OP_READ_FRONT, 32'h0,        8'd0,   1'b1, '{32'h0,        ST_RANGE, 9'd0, 1'b1}},
      '{OP_READ_BACK,  32'h0,        8'd0,   1'b1, '{32'h0,        ST_RANGE, 9'd0, 1'b1}},
      '{OP_READ_INDEX, 32'h0,        8'd0,   1'b1, '{32'h0,        ST_RANGE, 9'd0, 1'b1}},
      '{OP_READ_INDEX, 32'h0,        8'd255, 1'b1, '{32'h0,        ST_RANGE, 9'd0, 1'b1}},
      '{OP_CLEAR,      32'h0,        8'd0,   1'b1, '{32'h0,        ST_OK,    9'd0, 1'b1}},
      '{OP_PUSH_BACK,  32'h7FFFFFFF, 8'd0,   1'b1, '{32'h0,        ST_OK,    9'd1, 1'b0}},
      '{OP_PUSH_FRONT, 32'h80000000, 8'd0,   1'b1, '{32'h0,        ST_OK,    9'd2, 1'b0}},
      '{OP_READ_FRONT, 32'h0,        8'd0,   1'b1, '{32'h80000000, ST_OK,    9'd2, 1'b0}},
      '{OP_READ_BACK,  32'h0,        8'd0,   1'b1, '{32'h7FFFFFFF, ST_OK,    9'd2, 1'b0}},
      '{OP_READ_INDEX, 32'h0,        8'd1,   1'b1, '{32'h7FFFFFFF, ST_OK,    9'd2, 1'b0}},
      '{OP_READ_INDEX, 32'h0,        8'd2,   1'b1, '{32'h0,        ST_RANGE, 9'd2, 1'b0}},
      '{OP_READ_INDEX, 32'h0,        8'd255, 1'b1, '{32'h0,        ST_RANGE, 9'd2, 1'b0}},
      '{OP_RSVD_A,     32'hFFFFFFFF, 8'd0,   1'b1, '{32'h0,        ST_RANGE, 9'd2, 1'b0}},
      '{OP_RSVD_B,     32'h0,        8'd255, 1'b1, '{32'h0,        ST_RANGE, 9'd2, 1'b0}},
      '{OP_PUSH_BACK,  32'hFFFFFFFF, 8'd0,   1'b0, NO_WANT},
      '{OP_PUSH_FRONT, 32'h00000000, 8'd255, 1'b0, NO_WANT},
      '{OP_READ_INDEX, 32'h0,        8'd3,   1'b0, NO_WANT},
      '{OP_READ_INDEX, 32'h0,        8'd0,   1'b0, NO_WANT},
      '{OP_CLEAR,      32'h0,        8'd0,   1'b1, '{32'h0,        ST_OK,    9'd0, 1'b1}},
      '{OP_READ_BACK,  32'h0,        8'd0,   1'b1, '{32'h0,        ST_RANGE, 9'd0, 1'b1}},
      '{OP_PUSH_FRONT, 32'h5A5A5A5A, 8'd0,   1'b0, NO_WANT},
      '{OP_READ_BACK,  32'h0,        8'd0,   1'b0, NO_WANT}
   };

   double_ended_queue u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .req_index      (req_index),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_size       (rsp_size),
      .rsp_empty_res  (rsp_empty_res)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic outcome_t deque_apply(input logic [2:0] op, input logic [31:0] value,
                                            input logic [7:0] index);
      outcome_t   res;
      logic [7:0] pos;
      res = '{32'h0, ST_OK, 9'd0, 1'b0};
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (fill_count == DEPTH) begin
               res.status = ST_FULL;
            end else begin
               if (op == OP_PUSH_FRONT) begin
                  head_ptr = head_ptr - 8'd1;
                  pos = head_ptr;
               end else begin
                  pos = head_ptr + fill_count[7:0];
               end
               store_mem[pos] = value;
               fill_count = fill_count + 9'd1;
            end
         end
         OP_READ_INDEX: begin
            if ({1'b0, index} >= fill_count) begin
               res.status = ST_RANGE;
            end else begin
               pos = head_ptr + index;
               res.read_value = store_mem[pos];
            end
         end
         OP_READ_FRONT: begin
            if (fill_count == 9'd0) res.status = ST_RANGE;
            else res.read_value = store_mem[head_ptr];
         end
         OP_READ_BACK: begin
            if (fill_count == 9'd0) begin
               res.status = ST_RANGE;
            end else begin
               pos = head_ptr + fill_count[7:0] - 8'd1;
               res.read_value = store_mem[pos];
            end
         end
         OP_CLEAR: begin
            head_ptr = '0;
            fill_count = '0;
         end
         default: res.status = ST_RANGE;
      endcase
      res.size = fill_count;
      res.empty_res = (fill_count == 9'd0);
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_t got;
      outcome_t want;
      if (reset) begin
         head_ptr = '0;
         fill_count = '0;
      end else begin
         if (rsp_valid) begin
            got = '{rsp_read_value, rsp_status, rsp_size, rsp_empty_res};
            if (pending_results.size() == 0) begin
               if (fault_count < 10)
                  $display("unexpected transaction: value %h status %0d size %0d empty %0d",
                           got.read_value, got.status, got.size, got.empty_res);
               fault_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.read_value !== want.read_value || got.status !== want.status ||
                   got.size !== want.size || got.empty_res !== want.empty_res) begin
                  if (fault_count < 10)
                     $display("mismatch: value %h/%h status %0d/%0d size %0d/%0d empty %0d/%0d",
                              want.read_value, got.read_value, want.status, got.status,
                              want.size, got.size, want.empty_res, got.empty_res);
                  fault_count++;
               end
            end
         end
         if (start && !busy) begin
            want = deque_apply(req_operation, req_value, req_index);
            if (row_typed) want = row_expected;
            pending_results.insert(pending_results.size(), want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic issue(input logic [2:0] op, input logic [31:0] value, input logic [7:0] index,
                        input logic typed, input outcome_t want);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_value     <= value;
      req_index     <= index;
      row_typed     <= typed;
      row_expected  <= want;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      int         mode_left;
      int         push_w;
      int         clear_w;
      int         bad_w;
      int         w;
      int         r;
      logic [2:0] op;
      logic [7:0] idx;
      mode_left = 0;
      push_w = 0;
      clear_w = 0;
      bad_w = 0;
      for (int n = 0; n < count; n++) begin
         if (mode_left == 0) begin
            mode_left = $urandom_range(200, 20);
            case ($urandom_range(2))
               0:       begin push_w = 75; clear_w = 1; bad_w = 2; end
               1:       begin push_w = 40; clear_w = 4; bad_w = 4; end
               default: begin push_w = 10; clear_w = 3; bad_w = 3; end
            endcase
         end
         mode_left--;
         w = $urandom_range(99);
         if (w < push_w)
            op = ($urandom_range(1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
         else if (w < push_w + clear_w)
            op = OP_CLEAR;
         else if (w < push_w + clear_w + bad_w)
            op = ($urandom_range(1) != 0) ? OP_RSVD_A : OP_RSVD_B;
         else if (w % 3 == 0)
            op = OP_READ_FRONT;
         else if (w % 3 == 1)
            op = OP_READ_BACK;
         else
            op = OP_READ_INDEX;
         r = $urandom_range(9);
         if (r < 5 && gen_count > 0)
            idx = 8'($urandom_range(gen_count - 1));
         else if (r < 7)
            idx = (r == 5) ? 8'(gen_count) : 8'(gen_count - 1);
         else
            idx = 8'($urandom_range(255));
         if (op == OP_CLEAR)
            gen_count = 0;
         else if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && gen_count < DEPTH)
            gen_count++;
         issue(op, $urandom, idx, 1'b0, NO_WANT);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 17;
      foreach (directed_rows[i])
         issue(directed_rows[i].op, directed_rows[i].value, directed_rows[i].index,
               directed_rows[i].typed, directed_rows[i].want);
      issue(OP_CLEAR, 32'h0, 8'd0, 1'b0, NO_WANT);
      for (int k = 0; k < DEPTH + 2; k++)
         issue(($urandom_range(1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom,
               8'($urandom_range(255)), 1'b0, NO_WANT);
      issue(OP_READ_INDEX, 32'h0, 8'd255, 1'b0, NO_WANT);
      issue(OP_READ_INDEX, 32'h0, 8'd0, 1'b0, NO_WANT);
      issue(OP_READ_FRONT, 32'h0, 8'd0, 1'b0, NO_WANT);
      issue(OP_READ_BACK, 32'h0, 8'd0, 1'b0, NO_WANT);
      issue(OP_CLEAR, 32'h0, 8'd0, 1'b0, NO_WANT);
      gen_count = 0;
      run_random(455);
      idle_pct = 54;
      run_random(455);
      idle_pct = 0;
      run_random(455);
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fault_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
